// File: design/dfts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfts_pkg: shared constants and helpers
// hash constants and the fnv-1a byte step used by the token signature core
// ----------------------------------------------------------------------------
package dfts_pkg;

  localparam int unsigned MAX_BLOCK_TOKENS = 256;

  localparam int unsigned TOKEN_W = 32;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned LANE_W  = 64;
  localparam int unsigned BYTE_W  = 8;

  // byte steps per 64-bit word
  localparam int unsigned WORD_BYTES = LANE_W / BYTE_W;
  localparam int unsigned BYTE_CNT_W = $clog2(WORD_BYTES);

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] LEN_SALT  = 64'hd1b54a32d192ed03;
  localparam logic [63:0] TOK_SALT  = 64'ha0761d6478bd642f;
  localparam logic [63:0] COUNT_MUL = 64'hbf58476d1ce4e5b9;

  // one fnv-1a step: xor the byte, multiply by 2^40 + 0x1b3 modulo 2^64
  function automatic logic [63:0] fnv_step(input logic [63:0] lane,
                                           input logic [7:0]  b);
    logic [63:0] x;
    x = lane ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

// File: design/dfts_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfts_in_if: token input channel
// valid/ready channel carrying one token and the block length field
// ----------------------------------------------------------------------------
interface dfts_in_if;
  logic                              valid;
  logic                              ready;
  logic [dfts_pkg::TOKEN_W-1:0]      token;
  logic [dfts_pkg::LEN_W-1:0]        block_length;

  modport source (output valid, output token, output block_length, input ready);
  modport sink   (input valid, input token, input block_length, output ready);
endinterface

// File: design/dfts_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfts_out_if: signature result channel
// valid/ready channel carrying both lanes and the bucket hash
// ----------------------------------------------------------------------------
interface dfts_out_if;
  logic                           valid;
  logic                           ready;
  logic [dfts_pkg::LANE_W-1:0]    sig_low;
  logic [dfts_pkg::LANE_W-1:0]    sig_high;
  logic [dfts_pkg::LANE_W-1:0]    bucket_hash;

  modport source (output valid, output sig_low, output sig_high, output bucket_hash,
                  input ready);
  modport sink   (input valid, input sig_low, input sig_high, input bucket_hash,
                  output ready);
endinterface

// File: design/dual_fnv_token_block_signature_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_fnv_token_block_signature_core: dual-lane fnv-1a block signature
// hashes a block of 32-bit tokens into two 64-bit lanes plus a bucket hash
// ----------------------------------------------------------------------------
// The core takes one 32-bit token per item and folds it into two 64-bit
// fnv-1a lanes one byte per cycle, low byte first, through 64-bit shift
// registers, so each lane needs one xor and one shift-add multiply by the fnv
// prime per cycle. The first item of a block carries the length; it is
// saturated to MAX_BLOCK_TOKENS and absorbed first, then that item's token.
// Tokens in the middle of a block follow one another without a gap when the
// next item is already valid, since it is taken on the last byte step of the
// current one. After the last token the length is multiplied bit-serially by
// the count constant, and a finish step forms the bucket hash. A zero-length
// block emits after its length steps, the multiply and the finish step, and
// its token is dropped. The result sits in an output register, so a new
// block can start while the previous signature waits to be taken; the core
// only stalls when a second result is ready before the first is gone.
// ----------------------------------------------------------------------------
module dual_fnv_token_block_signature_core #(
  parameter int unsigned MAX_BLOCK_TOKENS = dfts_pkg::MAX_BLOCK_TOKENS
) (
  input  logic          clk,
  input  logic          rst_n,
  dfts_in_if.sink       in_ch,
  dfts_out_if.source    out_ch
);

  // token counter width, holds MAX_BLOCK_TOKENS itself
  localparam int unsigned CNT_W = $clog2(MAX_BLOCK_TOKENS + 1);
  // compare width for length saturation
  localparam int unsigned CMP_W = ((CNT_W > dfts_pkg::LEN_W) ? CNT_W : dfts_pkg::LEN_W) + 1;
  // bit counter for the serial count multiply
  localparam int unsigned MB_W  = (CNT_W > 1) ? $clog2(CNT_W) : 1;

  localparam int unsigned BC_W  = dfts_pkg::BYTE_CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_LEN,    // absorbing the block length
    ST_TOK,    // absorbing a token
    ST_MUL,    // serial length times count constant
    ST_FIN     // combine and load the output register
  } state_t;

  state_t           state_r;
  logic [BC_W-1:0]  byte_cnt_r;
  logic [CNT_W-1:0] tokens_left_r;
  logic [CNT_W-1:0] block_count_r;

  // lanes and their byte shift registers
  logic [63:0] low_lane_r;
  logic [63:0] high_lane_r;
  logic [63:0] low_word_r;
  logic [63:0] high_word_r;
  logic [dfts_pkg::TOKEN_W-1:0] token_r;

  // serial multiply
  logic [63:0]      prod_r;
  logic [63:0]      mcand_r;
  logic [CNT_W-1:0] n_sh_r;
  logic [MB_W-1:0]  mbit_r;

  // output register
  logic        out_valid_r;
  logic [63:0] sig_low_r;
  logic [63:0] sig_high_r;
  logic [63:0] bucket_hash_r;

  logic             last_byte;
  logic             in_fire;
  logic             out_free;
  logic [CMP_W-1:0] len_ext;
  logic [CNT_W-1:0] len_sat;
  logic [63:0]      low_step;
  logic [63:0]      high_step;
  logic [63:0]      mix_sum;
  logic [63:0]      mix_c;

  assign last_byte = (byte_cnt_r == BC_W'(dfts_pkg::WORD_BYTES - 1));

  // take a new item when idle, or on the last byte of a mid-block token
  assign in_ch.ready = (state_r == ST_IDLE) ||
                       ((state_r == ST_TOK) && last_byte && (tokens_left_r != CNT_W'(1)));
  assign in_fire     = in_ch.valid && in_ch.ready;

  // the output register can be reloaded when empty or drained this cycle
  assign out_free    = !out_valid_r || out_ch.ready;

  // length saturation
  assign len_ext = CMP_W'(in_ch.block_length);
  assign len_sat = (len_ext > CMP_W'(MAX_BLOCK_TOKENS)) ? CNT_W'(MAX_BLOCK_TOKENS)
                                                       : CNT_W'(in_ch.block_length);

  // one byte step per lane
  assign low_step  = dfts_pkg::fnv_step(low_lane_r,  low_word_r[7:0]);
  assign high_step = dfts_pkg::fnv_step(high_lane_r, high_word_r[7:0]);

  // bucket hash combine
  assign mix_sum = high_lane_r + dfts_pkg::GOLDEN + (low_lane_r << 6) + (low_lane_r >> 2);
  assign mix_c   = low_lane_r ^ mix_sum ^ prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      byte_cnt_r    <= '0;
      tokens_left_r <= '0;
      block_count_r <= '0;
      mbit_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // load on the finish step, otherwise drain independently
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // multiplier operands are primed before the multiply phase and held
      // through the finish step
      if ((state_r != ST_MUL) && (state_r != ST_FIN)) begin
        prod_r  <= '0;
        mcand_r <= dfts_pkg::COUNT_MUL;
        n_sh_r  <= block_count_r;
        mbit_r  <= '0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            token_r    <= in_ch.token;
            byte_cnt_r <= '0;
            if (tokens_left_r == '0) begin
              // first item of a block: reload lanes, absorb length
              block_count_r <= len_sat;
              tokens_left_r <= len_sat;
              low_lane_r    <= dfts_pkg::FNV_BASIS;
              high_lane_r   <= dfts_pkg::FNV_BASIS ^ dfts_pkg::GOLDEN;
              low_word_r    <= 64'(len_sat);
              high_word_r   <= 64'(len_sat) ^ dfts_pkg::LEN_SALT;
              state_r       <= ST_LEN;
            end else begin
              low_word_r  <= {32'd0, in_ch.token};
              high_word_r <= {in_ch.token ^ dfts_pkg::TOK_SALT[63:32],
                              dfts_pkg::TOK_SALT[31:0]};
              state_r     <= ST_TOK;
            end
          end
        end

        ST_LEN: begin
          low_lane_r  <= low_step;
          high_lane_r <= high_step;
          byte_cnt_r  <= byte_cnt_r + BC_W'(1);
          if (last_byte && (block_count_r != '0)) begin
            low_word_r  <= {32'd0, token_r};
            high_word_r <= {token_r ^ dfts_pkg::TOK_SALT[63:32],
                            dfts_pkg::TOK_SALT[31:0]};
          end else begin
            low_word_r  <= low_word_r >> dfts_pkg::BYTE_W;
            high_word_r <= high_word_r >> dfts_pkg::BYTE_W;
          end
          if (last_byte) begin
            if (block_count_r == '0) begin
              // empty block, token dropped
              state_r <= ST_MUL;
            end else begin
              state_r <= ST_TOK;
            end
          end
        end

        ST_TOK: begin
          low_lane_r  <= low_step;
          high_lane_r <= high_step;
          byte_cnt_r  <= byte_cnt_r + BC_W'(1);
          if (last_byte && in_fire) begin
            // next token of the block follows without a gap
            low_word_r  <= {32'd0, in_ch.token};
            high_word_r <= {in_ch.token ^ dfts_pkg::TOK_SALT[63:32],
                            dfts_pkg::TOK_SALT[31:0]};
          end else begin
            low_word_r  <= low_word_r >> dfts_pkg::BYTE_W;
            high_word_r <= high_word_r >> dfts_pkg::BYTE_W;
          end
          if (last_byte) begin
            tokens_left_r <= tokens_left_r - CNT_W'(1);
            if (tokens_left_r == CNT_W'(1)) begin
              state_r <= ST_MUL;
            end else if (!in_fire) begin
              state_r <= ST_IDLE;
            end
          end
        end

        ST_MUL: begin
          if (n_sh_r[0]) begin
            prod_r <= prod_r + mcand_r;
          end
          mcand_r <= mcand_r << 1;
          n_sh_r  <= n_sh_r >> 1;
          mbit_r  <= mbit_r + MB_W'(1);
          if (mbit_r == MB_W'(CNT_W - 1)) begin
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            sig_low_r     <= low_lane_r;
            sig_high_r    <= high_lane_r;
            bucket_hash_r <= mix_c ^ (mix_c >> 32);
            state_r       <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sig_low     = sig_low_r;
  assign out_ch.sig_high    = sig_high_r;
  assign out_ch.bucket_hash = bucket_hash_r;

`ifndef SYNTH
  // byte counter only runs while a word is being absorbed
  a_byte_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_MUL || state_r == ST_FIN) |-> (byte_cnt_r == '0))
    else $error("byte counter not at zero outside absorb phases");

  // remaining tokens never exceed the block length
  a_left_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    tokens_left_r <= block_count_r)
    else $error("tokens left exceeds block count");

  // a result is only formed once the block is used up
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN || state_r == ST_MUL) |-> (tokens_left_r == '0))
    else $error("finishing with tokens left");

  // a new result only comes out of the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised outside finish step");
`endif

endmodule

// File: sim/dual_fnv_token_block_signature_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_fnv_token_block_signature_core_tb: block signature self-checking bench
// walks a directed token table, then random blocks of mixed length, with
// bursty idling on both channels; every signature is checked against a
// behavioral model of the two fnv-1a lanes and the bucket hash
// ----------------------------------------------------------------------------
module dual_fnv_token_block_signature_core_tb;

  // fnv-1a 64-bit prime, 2^40 + 0x1b3
  localparam logic [63:0] FNV64_PRIME   = 64'h0000_0100_0000_01b3;
  localparam int unsigned RANDOM_ITEMS  = 800;
  // the last stretch of the run goes without any idling
  localparam int unsigned QUIET_ITEMS   = 120;
  // extra wait once every expected signature has been taken
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [dfts_pkg::TOKEN_W-1:0] token;
    logic [dfts_pkg::LEN_W-1:0]   block_length;
  } token_item_t;

  typedef struct packed {
    logic [dfts_pkg::LANE_W-1:0] sig_low;
    logic [dfts_pkg::LANE_W-1:0] sig_high;
    logic [dfts_pkg::LANE_W-1:0] bucket_hash;
  } signature_t;

  // directed rows: zero-length blocks, single-token extremes, and lengths
  // given inside a block that the core has to ignore
  localparam int unsigned N_DIRECTED = 14;
  localparam token_item_t DIRECTED_ITEMS [0:N_DIRECTED-1] = '{
    '{32'hffff_ffff, 9'd0},     // zero-length block, token dropped
    '{32'h0000_0000, 9'd0},     // zero-length block again
    '{32'h0000_0000, 9'd1},     // one token, all zeros
    '{32'hffff_ffff, 9'd1},     // one token, all ones
    '{32'h1234_5678, 9'd3},     // three tokens, mid lengths ignored
    '{32'ha5a5_a5a5, 9'h1ff},
    '{32'h5a5a_5a5a, 9'd0},
    '{32'h8000_0000, 9'd2},     // top bit of the token
    '{32'h0000_0001, 9'd100},
    '{32'hdead_beef, 9'd0},     // zero-length right after a block
    '{32'hffff_ffff, 9'd4},     // four tokens
    '{32'h0000_0000, 9'd256},
    '{32'h0f0f_0f0f, 9'd1},
    '{32'hf0f0_f0f0, 9'd255}
  };

  logic clk;
  logic rst_n;

  dfts_in_if  in_ch ();
  dfts_out_if out_ch ();

  dual_fnv_token_block_signature_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model state: both lanes, tokens still owed to the block, its length
  logic [dfts_pkg::LANE_W-1:0] lane_low;
  logic [dfts_pkg::LANE_W-1:0] lane_high;
  logic [dfts_pkg::LEN_W-1:0]  tokens_owed;
  logic [dfts_pkg::LEN_W-1:0]  block_len;

  signature_t  signature_q [$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          idle_en;

  // ---------------------------------------------------------------------------
  // signature model
  // ---------------------------------------------------------------------------

  // one 64-bit word into a lane, eight byte steps, low byte first
  function automatic logic [63:0] fnv_absorb(input logic [63:0] lane,
                                             input logic [63:0] word);
    logic [63:0] acc;
    acc = lane;
    for (int b = 0; b < 8; b++) begin
      acc = acc ^ ((word >> (8 * b)) & 64'hff);
      acc = acc * FNV64_PRIME;
    end
    return acc;
  endfunction

  function automatic signature_t form_signature(input logic [63:0] lo,
                                                input logic [63:0] hi,
                                                input logic [dfts_pkg::LEN_W-1:0] n);
    signature_t  s;
    logic [63:0] c;
    c = lo ^ (hi + dfts_pkg::GOLDEN + (lo << 6) + (lo >> 2));
    c = c ^ ({55'd0, n} * dfts_pkg::COUNT_MUL);
    s.sig_low     = lo;
    s.sig_high    = hi;
    s.bucket_hash = c ^ (c >> 32);
    return s;
  endfunction

  // advance the model by one accepted item; returns 1 when a block closes
  function automatic bit predict_signature(input token_item_t it,
                                           output signature_t sig);
    logic [dfts_pkg::LEN_W-1:0] n;
    logic [63:0]                tok;
    tok = {32'd0, it.token};
    sig = '0;
    if (tokens_owed == '0) begin
      // first item of a block: reload, saturate and absorb the length
      n = (it.block_length > dfts_pkg::MAX_BLOCK_TOKENS) ?
          dfts_pkg::LEN_W'(dfts_pkg::MAX_BLOCK_TOKENS) : it.block_length;
      block_len = n;
      lane_low  = fnv_absorb(dfts_pkg::FNV_BASIS, {55'd0, n});
      lane_high = fnv_absorb(dfts_pkg::FNV_BASIS ^ dfts_pkg::GOLDEN,
                             {55'd0, n} ^ dfts_pkg::LEN_SALT);
      if (n == '0) begin
        // zero-length block closes at once, its token is dropped
        sig = form_signature(lane_low, lane_high, block_len);
        return 1'b1;
      end
      tokens_owed = n;
    end
    lane_low    = fnv_absorb(lane_low, tok);
    lane_high   = fnv_absorb(lane_high, (tok << 32) ^ dfts_pkg::TOK_SALT);
    tokens_owed = tokens_owed - 1'b1;
    if (tokens_owed == '0) begin
      sig = form_signature(lane_low, lane_high, block_len);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, cycle limit
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // monitors: accepted input items feed the model, accepted results are
  // compared against the oldest expected signature
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    token_item_t it;
    signature_t  sig;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.token        = in_ch.token;
      it.block_length = in_ch.block_length;
      if (predict_signature(it, sig)) signature_q.push_back(sig);
    end
  end

  always @(posedge clk) begin
    signature_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (signature_q.size() == 0) begin
        $error("signature with no block pending: sig_low %h", out_ch.sig_low);
        error_count++;
      end else begin
        want = signature_q.pop_front();
        if (out_ch.sig_low !== want.sig_low) begin
          $error("sig_low expected %h actual %h", want.sig_low, out_ch.sig_low);
          error_count++;
        end
        if (out_ch.sig_high !== want.sig_high) begin
          $error("sig_high expected %h actual %h", want.sig_high, out_ch.sig_high);
          error_count++;
        end
        if (out_ch.bucket_hash !== want.bucket_hash) begin
          $error("bucket_hash expected %h actual %h", want.bucket_hash,
                 out_ch.bucket_hash);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side back-pressure: bursts of stall and of ready, none once
  // idling is switched off for the closing stretch
  // ---------------------------------------------------------------------------

  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (idle_en && ($urandom_range(0, 2) == 0)) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // token driver
  // ---------------------------------------------------------------------------

  // present one item, optionally after a gap, and hold it until taken;
  // valid stays high between back-to-back items
  task automatic send_token(input logic [dfts_pkg::TOKEN_W-1:0] tok,
                            input logic [dfts_pkg::LEN_W-1:0] len);
    if (idle_en && ($urandom_range(0, 4) == 0)) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.token        <= tok;
    in_ch.block_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // token values lean on the extremes now and then
  function automatic logic [dfts_pkg::TOKEN_W-1:0] pick_token();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one well-formed block; length fields inside the block are random noise
  task automatic send_block(input logic [dfts_pkg::LEN_W-1:0] len);
    int unsigned n;
    n = (len > dfts_pkg::MAX_BLOCK_TOKENS) ? dfts_pkg::MAX_BLOCK_TOKENS : len;
    send_token(pick_token(), len);
    for (int unsigned k = 1; k < n; k++) begin
      if (items_sent >= RANDOM_ITEMS + N_DIRECTED - QUIET_ITEMS) idle_en = 1'b0;
      send_token(pick_token(), dfts_pkg::LEN_W'($urandom));
    end
  endtask

  // mostly short blocks, some empty or medium, rarely a full or saturating one
  function automatic logic [dfts_pkg::LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)      return '0;
    else if (r < 75) return dfts_pkg::LEN_W'($urandom_range(1, 6));
    else if (r < 98) return dfts_pkg::LEN_W'($urandom_range(7, 40));
    else             return dfts_pkg::LEN_W'($urandom_range(256, 511));
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.token        = '0;
    in_ch.block_length = '0;
    out_ch.ready       = 1'b0;
    lane_low           = dfts_pkg::FNV_BASIS;
    lane_high          = dfts_pkg::FNV_BASIS ^ dfts_pkg::GOLDEN;
    tokens_owed        = '0;
    block_len          = '0;
    error_count        = 0;
    items_sent         = 0;
    cycle_count        = 0;
    idle_en            = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, every row checked by the model; it closes its last block
    for (int unsigned i = 0; i < N_DIRECTED; i++)
      send_token(DIRECTED_ITEMS[i].token, DIRECTED_ITEMS[i].block_length);

    // one saturating block early so it always runs
    send_block(dfts_pkg::LEN_W'($urandom_range(257, 511)));

    while (items_sent < RANDOM_ITEMS + N_DIRECTED) begin
      if (items_sent >= RANDOM_ITEMS + N_DIRECTED - QUIET_ITEMS) idle_en = 1'b0;
      send_block(pick_length());
    end

    in_ch.valid <= 1'b0;

    // drain: every block closed, then let the pipe settle
    while (signature_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
design/dfts_pkg.sv
design/dfts_in_if.sv
design/dfts_out_if.sv
design/dual_fnv_token_block_signature_core.sv
sim/dual_fnv_token_block_signature_core_tb.sv
